@@ hdl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sleep timer queue: result status codes,
// controller states and the command / status bundles between its parts.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 16;
    // Most requesters released by a single tick
    localparam int MAX_WAKES       = 16;
    // Width of a tick count or wake time
    localparam int TIME_W          = 63;
    localparam int ID_W            = 8;
    localparam int TICKS_W         = 32;
    localparam int STATUS_W        = 3;
    // Saturation value of the tick counter and of wake times
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    // Width of the per-tick release counter
    localparam int WAKE_CNT_W = $clog2(MAX_WAKES + 1);

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_QUEUED  = 3'd0,
        STAT_IGNORED = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_WOKEN   = 3'd3,
        STAT_NONE    = 3'd4
    } stq_status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SLEEP,
        S_TICK,
        S_WAKE
    } stq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic        load;        // capture the accepted item
        logic        tick_inc;    // advance the tick counter
        logic        insert;      // place the pending wake time in order
        logic        pop;         // drop the front entry
        logic        emit;        // load the result register
        stq_status_t emit_status;
        logic        emit_last;
    } stq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new result
        logic nonpos;     // captured sleep count is zero or negative
        logic full;       // queue holds QUEUE_DEPTH entries
        logic due;        // front entry is due at the current tick
        logic more;       // second entry is due at the current tick
    } stq_stat_t;

endpackage

@@ hdl/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller for the sleep timer queue: sequences item acceptance, sorted
// insert and the per-tick release of due requesters, one result per cycle while the result register is free.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  stq_pkg::stq_stat_t stat,
    output stq_pkg::stq_cmd_t  cmd
);
    import stq_pkg::*;

    stq_state_t            state_reg, state_next;
    logic [WAKE_CNT_W-1:0] wake_cnt_reg, wake_cnt_next;
    logic                  can_wake;
    logic                  more_ok;

    // Hold the state and the release counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wake_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            wake_cnt_reg <= wake_cnt_next;
        end
    end

    // Limit the number of releases per tick
    assign can_wake = stat.due && (wake_cnt_reg < WAKE_CNT_W'(MAX_WAKES));
    assign more_ok  = stat.more &&
                      ((WAKE_CNT_W+1)'(wake_cnt_reg) + (WAKE_CNT_W+1)'(1)
                       < (WAKE_CNT_W+1)'(MAX_WAKES));

    // Next state and commands
    always_comb begin
        state_next      = state_reg;
        wake_cnt_next   = wake_cnt_reg;
        s_ready         = 1'b0;
        cmd.load        = 1'b0;
        cmd.tick_inc    = 1'b0;
        cmd.insert      = 1'b0;
        cmd.pop         = 1'b0;
        cmd.emit        = 1'b0;
        cmd.emit_status = STAT_QUEUED;
        cmd.emit_last   = 1'b1;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s_action ? S_TICK : S_SLEEP;
                end
            end
            S_SLEEP: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (stat.nonpos) begin
                        cmd.emit_status = STAT_IGNORED;
                    end else if (stat.full) begin
                        cmd.emit_status = STAT_FULL;
                    end else begin
                        cmd.emit_status = STAT_QUEUED;
                        cmd.insert      = 1'b1;
                    end
                end
            end
            S_TICK: begin
                cmd.tick_inc  = 1'b1;
                wake_cnt_next = '0;
                state_next    = S_WAKE;
            end
            S_WAKE: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (can_wake) begin
                        // Release the front requester
                        cmd.emit_status = STAT_WOKEN;
                        cmd.emit_last   = !more_ok;
                        cmd.pop         = 1'b1;
                        wake_cnt_next   = wake_cnt_reg + WAKE_CNT_W'(1);
                        if (!more_ok) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        cmd.emit_status = STAT_NONE;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/stq_datapath.sv @@
// ----------------------------------------------------------------------------
// stq_datapath
// Datapath for the sleep timer queue: tick counter, sorted shift-line queue
// of wake times and ids, captured item and the result register.
// ----------------------------------------------------------------------------
module stq_datapath #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [stq_pkg::ID_W-1:0]      s_requester_id,
    input  logic signed [stq_pkg::TICKS_W-1:0] s_sleep_ticks,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [stq_pkg::STATUS_W-1:0]  m_status,
    output logic [stq_pkg::ID_W-1:0]      m_woken_id,
    output logic [stq_pkg::TIME_W-1:0]    m_tick_now,
    output logic                          m_last,
    input  stq_pkg::stq_cmd_t             cmd,
    output stq_pkg::stq_stat_t            stat
);
    import stq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0]   tick_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [TIME_W-1:0]   wake_times_reg [QUEUE_DEPTH];
    logic [ID_W-1:0]     waiting_ids_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0]   wake_reg;
    logic [ID_W-1:0]     id_reg;
    logic                nonpos_reg;
    logic                m_valid_reg;
    stq_status_t         m_status_reg;
    logic [ID_W-1:0]     m_woken_id_reg;
    logic [TIME_W-1:0]   m_tick_now_reg;
    logic                m_last_reg;
    logic [TIME_W:0]     wake_sum;
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] le_prev;

    // Wake time from the input count, saturated at the top of the range
    assign wake_sum = {1'b0, tick_reg} + (TIME_W+1)'(s_sleep_ticks[TICKS_W-2:0]);

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg     <= s_requester_id;
            nonpos_reg <= s_sleep_ticks[TICKS_W-1] || (s_sleep_ticks == '0);
            wake_reg   <= wake_sum[TIME_W] ? TIME_MAX : wake_sum[TIME_W-1:0];
        end
    end

    // Advance the tick counter and track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            occ_reg  <= '0;
        end else begin
            if (cmd.tick_inc && (tick_reg != TIME_MAX)) begin
                tick_reg <= tick_reg + TIME_W'(1);
            end
            if (cmd.insert) begin
                occ_reg <= occ_reg + OCC_W'(1);
            end else if (cmd.pop) begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

    // Queue entries: each compares against the pending wake time, and
    // entries at or before it form a prefix of the sorted queue
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
        assign le[i] = (occ_reg > OCC_W'(i)) && (wake_times_reg[i] <= wake_reg);

        if (i == 0) begin : g_head
            assign le_prev[i] = 1'b0;
        end else begin : g_body
            assign le_prev[i] = le[i-1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.insert) begin
                if (!le[i]) begin
                    if ((i == 0) || le_prev[i]) begin
                        wake_times_reg[i]  <= wake_reg;
                        waiting_ids_reg[i] <= id_reg;
                    end else begin
                        wake_times_reg[i]  <= wake_times_reg[(i == 0) ? 0 : i-1];
                        waiting_ids_reg[i] <= waiting_ids_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (cmd.pop && (i < QUEUE_DEPTH - 1)) begin
                wake_times_reg[i]  <= wake_times_reg[(i < QUEUE_DEPTH - 1) ? i+1 : i];
                waiting_ids_reg[i] <= waiting_ids_reg[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            end
        end
    end

    // Due checks on the two front entries
    assign stat.due = (occ_reg != '0) && (wake_times_reg[0] <= tick_reg);
    if (QUEUE_DEPTH > 1) begin : g_more
        assign stat.more = (occ_reg > OCC_W'(1)) && (wake_times_reg[1] <= tick_reg);
    end else begin : g_no_more
        assign stat.more = 1'b0;
    end

    assign stat.nonpos   = nonpos_reg;
    assign stat.full     = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign stat.out_free = !m_valid_reg || m_ready;

    // Result register: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg   <= cmd.emit_status;
            m_woken_id_reg <= (cmd.emit_status == STAT_WOKEN) ? waiting_ids_reg[0] : '0;
            m_tick_now_reg <= tick_reg;
            m_last_reg     <= cmd.emit_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_woken_id = m_woken_id_reg;
    assign m_tick_now = m_tick_now_reg;
    assign m_last     = m_last_reg;

endmodule

@@ hdl/sleep_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sleep_timer_queue
// Sorted alarm queue for sleeping requesters, with a saturating tick counter.
// ----------------------------------------------------------------------------
// A sleep item (action 0) with a positive count queues wake time now + count
// behind any equal times and returns one result: queued, ignored for a count
// of zero or less, or rejected when full. A tick item (action 1) advances
// the counter and returns one result per released requester, front first,
// up to sixteen, or a single "none woken" result; the final result of an
// item has last set. The block takes one item at a time. A sleep item is
// captured with its wake-time add, then inserted as its result is loaded;
// the insert compares every entry in parallel and shifts the tail. A tick
// item advances the counter, then the controller emits one result per
// cycle through a single result register while m_ready does not stall it.
// No clearing pass is needed after reset.
module sleep_timer_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [stq_pkg::ID_W-1:0]           s_requester_id,
    input  logic signed [stq_pkg::TICKS_W-1:0] s_sleep_ticks,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [stq_pkg::STATUS_W-1:0]       m_status,
    output logic [stq_pkg::ID_W-1:0]           m_woken_id,
    output logic [stq_pkg::TIME_W-1:0]         m_tick_now,
    output logic                               m_last
);
    import stq_pkg::*;

    stq_cmd_t  cmd;
    stq_stat_t stat;

    // Sequence the work
    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the queue and the result
    stq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_requester_id (s_requester_id),
        .s_sleep_ticks  (s_sleep_ticks),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_woken_id     (m_woken_id),
        .m_tick_now     (m_tick_now),
        .m_last         (m_last),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

@@ hdl/stq_checker.sv @@
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sleep timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [stq_pkg::STATUS_W-1:0]      m_status,
    input logic [stq_pkg::ID_W-1:0]          m_woken_id,
    input logic [stq_pkg::TIME_W-1:0]        m_tick_now,
    input logic                              m_last
);
    import stq_pkg::*;

    // Every status other than woken closes its item
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_WOKEN)) |-> m_last)
        else $error("non-woken result without last");

    // An id is reported only for a released requester
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_WOKEN)) |-> (m_woken_id == '0))
        else $error("woken_id set on a non-woken result");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken in consecutive cycles");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) &&
                                   $stable(m_tick_now) && $stable(m_last)))
        else $error("stalled result changed");

endmodule

bind sleep_timer_queue stq_checker u_stq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_woken_id (m_woken_id),
    .m_tick_now (m_tick_now),
    .m_last     (m_last)
);

@@ verif/sleep_timer_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sleep_timer_queue_tb
// Self-checking bench for the sorted sleep timer queue. A behavioral copy of
// the queue predicts every result when a sleep or tick transfer is accepted.
// A monitor compares each result transfer, field by field, with the oldest
// prediction. Directed tests cover ignored counts, equal wake times, a full
// queue and a mass wake-up. Random traffic runs under changing idle and
// back-pressure patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sleep_timer_queue_tb;

    import stq_pkg::*;

    localparam int DEPTH      = QUEUE_DEPTH_DEF;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL_WAIT  = 20;
    localparam logic ACT_SLEEP = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam logic signed [TICKS_W-1:0] TICKS_MIN = 32'sh8000_0000;
    localparam logic signed [TICKS_W-1:0] TICKS_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        stq_status_t       status;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic              last;
    } wake_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_action;
    logic [ID_W-1:0]            s_requester_id;
    logic signed [TICKS_W-1:0]  s_sleep_ticks;
    logic                       m_valid;
    logic                       m_ready;
    logic [STATUS_W-1:0]        m_status;
    logic [ID_W-1:0]            m_woken_id;
    logic [TIME_W-1:0]          m_tick_now;
    logic                       m_last;

    // Predicted queue contents and tick counter
    logic [TIME_W-1:0] alarm_time [DEPTH];
    logic [ID_W-1:0]   alarm_id   [DEPTH];
    int                alarm_count;
    logic [TIME_W-1:0] now_ticks;

    wake_result_t pending_results[$];

    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int stall_cycles;

    sleep_timer_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_requester_id (s_requester_id),
        .s_sleep_ticks  (s_sleep_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_woken_id     (m_woken_id),
        .m_tick_now     (m_tick_now),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Advance the predicted queue by one accepted item and queue its results
    task automatic advance_alarm_model(input logic act, input logic [ID_W-1:0] id,
                                       input logic signed [TICKS_W-1:0] ticks);
        wake_result_t      res;
        logic [TIME_W:0]   wake_sum;
        logic [TIME_W-1:0] wake;
        int                pos;
        int                i;
        int                woken;
        begin
            res.id   = '0;
            res.last = 1'b1;
            if (act == ACT_TICK) begin
                if (now_ticks != TIME_MAX)
                    now_ticks = now_ticks + TIME_W'(1);
                res.now = now_ticks;
                woken   = 0;
                // Release due entries from the front, flag the final one
                while (woken < MAX_WAKES && alarm_count > 0 && alarm_time[0] <= now_ticks) begin
                    if (woken > 0) begin
                        res.last = 1'b0;
                        pending_results.push_back(res);
                    end
                    res.status = STAT_WOKEN;
                    res.id     = alarm_id[0];
                    res.last   = 1'b1;
                    for (i = 1; i < alarm_count; i++) begin
                        alarm_time[i-1] = alarm_time[i];
                        alarm_id[i-1]   = alarm_id[i];
                    end
                    alarm_count--;
                    woken++;
                end
                if (woken == 0)
                    res.status = STAT_NONE;
                pending_results.push_back(res);
            end else begin
                res.now = now_ticks;
                if (ticks <= 0) begin
                    res.status = STAT_IGNORED;
                end else if (alarm_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    wake_sum = {1'b0, now_ticks} + {32'd0, ticks};
                    wake     = (wake_sum > {1'b0, TIME_MAX}) ? TIME_MAX : wake_sum[TIME_W-1:0];
                    // Place behind every entry with an equal or earlier time
                    pos = 0;
                    while (pos < alarm_count && alarm_time[pos] <= wake)
                        pos++;
                    for (i = alarm_count; i > pos; i--) begin
                        alarm_time[i] = alarm_time[i-1];
                        alarm_id[i]   = alarm_id[i-1];
                    end
                    alarm_time[pos] = wake;
                    alarm_id[pos]   = id;
                    alarm_count++;
                    res.status = STAT_QUEUED;
                end
                pending_results.push_back(res);
            end
        end
    endtask

    // Offer one item after random idle cycles and hold it until the transfer
    task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                             input logic signed [TICKS_W-1:0] ticks);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            @(negedge aclk);
            s_valid        <= 1'b1;
            s_action       <= act;
            s_requester_id <= id;
            s_sleep_ticks  <= ticks;
            do @(posedge aclk); while (!s_ready);
            advance_alarm_model(act, id, ticks);
        end
    endtask

    // Drop valid and hold until every predicted result has arrived
    task automatic wait_results_drained();
        begin
            @(negedge aclk);
            s_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge aclk);
        end
    endtask

    task automatic test_empty_tick();
        begin
            send_item(ACT_TICK, 8'h00, 32'sd0);
        end
    endtask

    task automatic test_nonpositive_sleep();
        begin
            send_item(ACT_SLEEP, 8'h00, 32'sd0);
            send_item(ACT_SLEEP, 8'hFF, -32'sd1);
            send_item(ACT_SLEEP, 8'hA5, TICKS_MIN);
        end
    endtask

    // Equal wake times release in arrival order
    task automatic test_equal_time_order();
        begin
            send_item(ACT_SLEEP, 8'h00, 32'sd2);
            send_item(ACT_SLEEP, 8'h5A, 32'sd1);
            send_item(ACT_SLEEP, 8'hC3, 32'sd2);
            send_item(ACT_TICK, 8'h00, 32'sd0);
            send_item(ACT_TICK, 8'h00, 32'sd0);
        end
    endtask

    // Fill the queue, overflow it, then wake every entry on one tick
    task automatic test_full_queue();
        begin
            while (alarm_count < DEPTH)
                send_item(ACT_SLEEP, 8'($urandom()), 32'sd1);
            send_item(ACT_SLEEP, 8'h77, 32'sd1);
            send_item(ACT_TICK, 8'hFF, TICKS_MAX);
        end
    endtask

    task automatic test_max_sleep();
        begin
            send_item(ACT_SLEEP, 8'hFF, TICKS_MAX);
        end
    endtask

    // Stall the result side for a long stretch while items keep coming
    task automatic test_result_backpressure();
        int n;
        begin
            hold_left = 150;
            for (n = 0; n < 12; n++)
                send_item(n[0] ? ACT_TICK : ACT_SLEEP, 8'($urandom()),
                          32'($urandom_range(1, 6)));
            wait_results_drained();
        end
    endtask

    task automatic test_random_traffic(input int count);
        int                        n;
        int                        sleep_pct;
        logic                      act;
        logic [ID_W-1:0]           id;
        logic signed [TICKS_W-1:0] ticks;
        begin
            sleep_pct = 50;
            for (n = 0; n < count; n++) begin
                // Shift the sleep / tick mix so the queue fills and empties
                if (n % 20 == 0)
                    sleep_pct = $urandom_range(25, 85);
                if (n % 45 == 44)
                    wait_results_drained();
                act = ($urandom_range(99) >= sleep_pct) ? ACT_TICK : ACT_SLEEP;
                id  = 8'($urandom());
                case ($urandom_range(9))
                    0: ticks = {1'b1, 31'($urandom())};
                    1: ticks = 32'sd0 - 32'($urandom_range(0, 4));
                    2: ticks = 32'($urandom_range(13, 150));
                    default: ticks = 32'($urandom_range(1, 12));
                endcase
                send_item(act, id, ticks);
            end
        end
    endtask

    // Drive the result-side ready with random stalls or a forced hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        wake_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d id %0d tick_now %0d last %0d",
                       m_status, m_woken_id, m_tick_now, m_last);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, m_status);
                    fail_count++;
                end
                if (m_woken_id !== exp_res.id) begin
                    $error("woken_id: expected %0d, actual %0d", exp_res.id, m_woken_id);
                    fail_count++;
                end
                if (m_tick_now !== exp_res.now) begin
                    $error("tick_now: expected %0d, actual %0d", exp_res.now, m_tick_now);
                    fail_count++;
                end
                if (m_last !== exp_res.last) begin
                    $error("last: expected %0d, actual %0d", exp_res.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_SLEEP;
        s_requester_id = '0;
        s_sleep_ticks  = '0;
        m_ready        = 1'b0;
        fail_count     = 0;
        hold_left      = 0;
        stall_cycles   = 0;
        alarm_count    = 0;
        now_ticks      = '0;
        send_idle_pct  = 22;
        recv_idle_pct  = 63;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_tick();
        test_nonpositive_sleep();
        test_equal_time_order();
        test_full_queue();
        test_max_sleep();
        test_result_backpressure();
        test_random_traffic(57);

        send_idle_pct = 63;
        recv_idle_pct = 22;
        test_random_traffic(57);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(57);

        wait_results_drained();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/stq_pkg.sv
hdl/stq_ctrl.sv
hdl/stq_datapath.sv
hdl/sleep_timer_queue.sv
hdl/stq_checker.sv
verif/sleep_timer_queue_tb.sv
